// File: design/pmfti_pkg.sv
// pmfti_pkg: shared widths, register map, indicator codes and config struct
// used by every module of the pitch mode filter and tuning indicator
package pmfti_pkg;

    // history ring geometry
    localparam int HISTORY_DEPTH = 10;
    localparam int PTR_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);

    // field widths
    localparam int BIN_W    = 9;
    localparam int MAG_W    = 32;
    localparam int TARGET_W = 22;
    localparam int MINF_W   = 22;
    localparam int WIN_W    = 17;
    localparam int STEP_W   = 16;
    localparam int IND_W    = 5;
    localparam int FREQ_W   = BIN_W + STEP_W;
    localparam int DIFF_W   = FREQ_W + 1;

    // apb port
    localparam int DATA_W = 32;
    localparam int ADDR_W = 5;
    localparam int IDX_W  = 3;

    // register indexes
    localparam logic [IDX_W-1:0] REG_TARGET = 3'd0;
    localparam logic [IDX_W-1:0] REG_NOISE  = 3'd1;
    localparam logic [IDX_W-1:0] REG_MINF   = 3'd2;
    localparam logic [IDX_W-1:0] REG_FINE   = 3'd3;
    localparam logic [IDX_W-1:0] REG_COARSE = 3'd4;
    localparam logic [IDX_W-1:0] REG_STEP   = 3'd5;

    // register reset values
    localparam logic [TARGET_W-1:0] RST_TARGET = 22'd267909;
    localparam logic [MAG_W-1:0]    RST_NOISE  = 32'd500;
    localparam logic [MINF_W-1:0]   RST_MINF   = 22'd76800;
    localparam logic [WIN_W-1:0]    RST_FINE   = 17'd3072;
    localparam logic [WIN_W-1:0]    RST_COARSE = 17'd10240;
    localparam logic [STEP_W-1:0]   RST_STEP   = 16'd5000;

    // indicator codes
    localparam logic [IND_W-1:0] IND_OFF        = 5'h00;
    localparam logic [IND_W-1:0] IND_VERY_FLAT  = 5'h03;
    localparam logic [IND_W-1:0] IND_FLAT       = 5'h02;
    localparam logic [IND_W-1:0] IND_IN_TUNE    = 5'h04;
    localparam logic [IND_W-1:0] IND_SHARP      = 5'h08;
    localparam logic [IND_W-1:0] IND_VERY_SHARP = 5'h18;

    typedef struct packed {
        logic [TARGET_W-1:0] target_freq_q10;
        logic [MAG_W-1:0]    mag_floor;
        logic [MINF_W-1:0]   min_freq_q10;
        logic [WIN_W-1:0]    fine_window_q10;
        logic [WIN_W-1:0]    coarse_window_q10;
        logic [STEP_W-1:0]   bin_step_q10;
    } cfg_t;

endpackage

// File: design/pmfti_regs.sv
// pmfti_regs: apb configuration register file
// depends on pmfti_pkg for the register map and cfg_t
module pmfti_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pmfti_pkg::ADDR_W-1:0]  paddr,
    input  logic [pmfti_pkg::DATA_W-1:0]  pwdata,
    output logic [pmfti_pkg::DATA_W-1:0]  prdata,
    output logic                          pready,
    output pmfti_pkg::cfg_t               cfg
);
    import pmfti_pkg::*;

    cfg_t              cfg_reg;
    logic [IDX_W-1:0]  reg_idx;
    logic              wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign wr_en   = psel & penable & pwrite;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target_freq_q10   <= RST_TARGET;
            cfg_reg.mag_floor         <= RST_NOISE;
            cfg_reg.min_freq_q10      <= RST_MINF;
            cfg_reg.fine_window_q10   <= RST_FINE;
            cfg_reg.coarse_window_q10 <= RST_COARSE;
            cfg_reg.bin_step_q10      <= RST_STEP;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_TARGET: cfg_reg.target_freq_q10   <= pwdata[TARGET_W-1:0];
                REG_NOISE:  cfg_reg.mag_floor         <= pwdata[MAG_W-1:0];
                REG_MINF:   cfg_reg.min_freq_q10      <= pwdata[MINF_W-1:0];
                REG_FINE:   cfg_reg.fine_window_q10   <= pwdata[WIN_W-1:0];
                REG_COARSE: cfg_reg.coarse_window_q10 <= pwdata[WIN_W-1:0];
                REG_STEP:   cfg_reg.bin_step_q10      <= pwdata[STEP_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_TARGET: prdata = DATA_W'(cfg_reg.target_freq_q10);
            REG_NOISE:  prdata = DATA_W'(cfg_reg.mag_floor);
            REG_MINF:   prdata = DATA_W'(cfg_reg.min_freq_q10);
            REG_FINE:   prdata = DATA_W'(cfg_reg.fine_window_q10);
            REG_COARSE: prdata = DATA_W'(cfg_reg.coarse_window_q10);
            REG_STEP:   prdata = DATA_W'(cfg_reg.bin_step_q10);
            default:    prdata = '0;
        endcase
    end

endmodule

// File: design/pmfti_mode.sv
// pmfti_mode: bin history ring and mode search, one candidate per cycle
// depends on pmfti_pkg for ring depth and widths
module pmfti_mode (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [pmfti_pkg::BIN_W-1:0] bin,
    output logic                        done,
    output logic [pmfti_pkg::BIN_W-1:0] stable_bin
);
    import pmfti_pkg::*;

    logic [BIN_W-1:0] hist_reg [HISTORY_DEPTH];
    logic [PTR_W-1:0] wptr_reg;
    logic [PTR_W-1:0] idx_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [BIN_W-1:0] best_reg;
    logic [CNT_W-1:0] best_cnt_reg;

    logic [BIN_W-1:0] cand;
    logic [CNT_W-1:0] cnt;
    logic             last_idx;

    // shared counting unit: candidate against every ring entry
    always_comb
    begin
        cand = hist_reg[idx_reg];
        cnt  = '0;
        for (int j = 0; j < HISTORY_DEPTH; j++)
        begin
            cnt = cnt + CNT_W'(hist_reg[j] == cand);
        end
    end

    assign last_idx = (idx_reg == PTR_W'(HISTORY_DEPTH - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < HISTORY_DEPTH; k++)
            begin
                hist_reg[k] <= '0;
            end
            wptr_reg     <= '0;
            idx_reg      <= '0;
            busy_reg     <= 1'b0;
            done_reg     <= 1'b0;
            best_reg     <= '0;
            best_cnt_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                hist_reg[wptr_reg] <= bin;
                wptr_reg     <= (wptr_reg == PTR_W'(HISTORY_DEPTH - 1)) ? '0
                                                                        : wptr_reg + 1'b1;
                idx_reg      <= '0;
                busy_reg     <= 1'b1;
                best_reg     <= '0;
                best_cnt_reg <= '0;
            end
            else if (busy_reg)
            begin
                // first strictly higher count wins
                if (cnt > best_cnt_reg)
                begin
                    best_cnt_reg <= cnt;
                    best_reg     <= cand;
                end
                if (last_idx)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                    idx_reg  <= '0;
                end
                else
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end
        end
    end

    assign done       = done_reg;
    assign stable_bin = best_reg;

endmodule

// File: design/pmfti_judge.sv
// pmfti_judge: frequency multiply, difference and window classification
// depends on pmfti_pkg for cfg_t, widths and indicator codes
module pmfti_judge (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [pmfti_pkg::BIN_W-1:0] bin,
    input  logic [pmfti_pkg::MAG_W-1:0] mag,
    input  pmfti_pkg::cfg_t             cfg,
    output logic                        done,
    output logic [pmfti_pkg::IND_W-1:0] ind
);
    import pmfti_pkg::*;

    logic                     s1_reg, s2_reg, s3_reg;
    logic [FREQ_W-1:0]        freq_reg;
    logic                     mag_ok_reg;
    logic                     on_reg;
    logic signed [DIFF_W-1:0] diff_reg;
    logic [IND_W-1:0]         ind_reg;

    logic signed [DIFF_W-1:0] fine_s, coarse_s;
    logic [IND_W-1:0]         ind_next;

    always_comb
    begin
        fine_s   = $signed(DIFF_W'(cfg.fine_window_q10));
        coarse_s = $signed(DIFF_W'(cfg.coarse_window_q10));
        if (!on_reg)
            ind_next = IND_OFF;
        else if (diff_reg >= -fine_s && diff_reg <= fine_s)
            ind_next = IND_IN_TUNE;
        else if (diff_reg >= -coarse_s && diff_reg < -fine_s)
            ind_next = IND_FLAT;
        else if (diff_reg < -coarse_s)
            ind_next = IND_VERY_FLAT;
        else if (diff_reg > fine_s && diff_reg <= coarse_s)
            ind_next = IND_SHARP;
        else
            ind_next = IND_VERY_SHARP;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg <= 1'b0;
            s2_reg <= 1'b0;
            s3_reg <= 1'b0;
        end
        else
        begin
            s1_reg <= start;
            s2_reg <= s1_reg;
            s3_reg <= s2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        // stage 1: multiply and magnitude gate
        if (start)
        begin
            freq_reg   <= FREQ_W'(bin) * FREQ_W'(cfg.bin_step_q10);
            mag_ok_reg <= (mag >= cfg.mag_floor);
        end
        // stage 2: signed difference and minimum frequency gate
        if (s1_reg)
        begin
            diff_reg <= $signed({1'b0, freq_reg}) - $signed(DIFF_W'(cfg.target_freq_q10));
            on_reg   <= mag_ok_reg && (freq_reg >= FREQ_W'(cfg.min_freq_q10));
        end
        // stage 3: window classification
        if (s2_reg)
        begin
            ind_reg <= ind_next;
        end
    end

    assign done = s3_reg;
    assign ind  = ind_reg;

endmodule

// File: design/pitch_mode_filter_tuning_indicator.sv
// pitch_mode_filter_tuning_indicator: top level with sequencer and output register
// depends on pmfti_pkg, pmfti_regs, pmfti_mode and pmfti_judge

// One word in per analysis frame: a peak bin and its magnitude. The bin goes into a
// ten-entry history ring, the mode of the ring is reported as stable_bin, and five
// indicator bits compare stable_bin * bin_step_q10 against the target frequency.
// Each input word runs from acceptance to out_valid as follows: the ring is written at
// the accepting edge, then a single compare-and-count unit scores the ten ring entries,
// one per cycle, then multiply, subtract and window classification are registered in
// turn, and the output register is loaded. in_stall is high from acceptance until the
// result is loaded, so the block takes no new word while one is in flight. A result
// waiting on out_stall does not block the next word until its own result is ready.
// Configuration registers sit on an apb port at byte address 4*index and should only
// be written while no word is in flight.
module pitch_mode_filter_tuning_indicator (
    input  logic                          clk,
    input  logic                          rst_n,
    // input channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [pmfti_pkg::BIN_W-1:0]   peak_bin,
    input  logic [pmfti_pkg::MAG_W-1:0]   peak_magnitude,
    // output channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [pmfti_pkg::BIN_W-1:0]   stable_bin,
    output logic [pmfti_pkg::IND_W-1:0]   indicator_bits,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pmfti_pkg::ADDR_W-1:0]  paddr,
    input  logic [pmfti_pkg::DATA_W-1:0]  pwdata,
    output logic [pmfti_pkg::DATA_W-1:0]  prdata,
    output logic                          pready
);
    import pmfti_pkg::*;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_BUSY = 3'b010,
        S_HOLD = 3'b100
    } state_t;

    state_t           state_reg, state_next;
    cfg_t             cfg;

    logic [MAG_W-1:0] mag_reg;
    logic             out_valid_reg, out_valid_next;
    logic [BIN_W-1:0] out_bin_reg;
    logic [IND_W-1:0] out_ind_reg;

    logic             accept;
    logic             out_free;
    logic             load_out;
    logic             mode_done;
    logic [BIN_W-1:0] mode_bin;
    logic             judge_done;
    logic [IND_W-1:0] judge_ind;

    pmfti_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // ring write on acceptance, then the mode scan
    pmfti_mode u_mode (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (accept),
        .bin        (peak_bin),
        .done       (mode_done),
        .stable_bin (mode_bin)
    );

    // classification starts the cycle the scan finishes
    pmfti_judge u_judge (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mode_done),
        .bin   (mode_bin),
        .mag   (mag_reg),
        .cfg   (cfg),
        .done  (judge_done),
        .ind   (judge_ind)
    );

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && (state_reg == S_IDLE);
    // output register is free when empty or being taken this cycle
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        load_out   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_BUSY;
            end
            S_BUSY:
            begin
                if (judge_done)
                begin
                    if (out_free)
                    begin
                        load_out   = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_HOLD;
                    end
                end
            end
            S_HOLD:
            begin
                // finished word waits for the previous one to drain
                if (out_free)
                begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (load_out)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
            mag_reg <= peak_magnitude;
        if (load_out)
        begin
            out_bin_reg <= mode_bin;
            out_ind_reg <= judge_ind;
        end
    end

    assign out_valid      = out_valid_reg;
    assign stable_bin     = out_bin_reg;
    assign indicator_bits = out_ind_reg;

endmodule
